### hdl/brenc_pkg.sv
// Shared types and constants for the binary range encoder.
// Used by the front, queue, back and top modules; depends on nothing else.
package brenc_pkg;

	localparam int PROB_BITS_DEF   = 12;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int BOUND_W     = 64;
	localparam int HALF_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int FLUSH_BYTES = 8;
	localparam int CNT_W       = $clog2(FLUSH_BYTES);

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Classification of one queued command.
	typedef struct packed {
		logic finish;
		logic bit_value;
	} brenc_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SCALE,
		ST_NARROW,
		ST_RENORM,
		ST_FLUSH
	} brenc_state_t;

endpackage

### hdl/brenc_front.sv
// Input side of the binary range encoder: classifies each beat and clamps the probability.
// Depends on brenc_pkg.
module brenc_front #(
	parameter int PROB_BITS = brenc_pkg::PROB_BITS_DEF,
	parameter int IN_DATA_W = 16,
	parameter int ENTRY_W   = PROB_BITS + 2
) (
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic                 s_user,
	input  logic [IN_DATA_W-1:0] s_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [ENTRY_W-1:0]   push_data
);
	import brenc_pkg::*;

	logic [PROB_BITS-1:0] p1;
	logic [PROB_BITS-1:0] p1_clamped;
	logic [PROB_BITS:0]   p0_wide;
	brenc_flags_t         flags;

	always_comb begin
		p1         = s_data[PROB_BITS:1];
		// A probability of zero is pulled up to the smallest legal value.
		p1_clamped = (p1 == '0) ? PROB_BITS'(1) : p1;
		p0_wide    = {1'b1, {PROB_BITS{1'b0}}} - {1'b0, p1_clamped};
		flags.finish    = (s_user == CMD_FINISH);
		flags.bit_value = s_data[0];
	end

	assign push_data  = {p0_wide[PROB_BITS-1:0], flags};
	assign push_valid = s_valid;
	assign s_ready    = push_ready;

endmodule

### hdl/brenc_queue.sv
// Small register queue that decouples the input side from the interval engine.
// Depends on brenc_pkg only for its default depth.
module brenc_queue #(
	parameter int WIDTH = 14,
	parameter int DEPTH = brenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/brenc_back.sv
// Interval engine of the binary range encoder: range, split, narrowing, byte output.
// Depends on brenc_pkg; fed by brenc_queue.
module brenc_back #(
	parameter int PROB_BITS = brenc_pkg::PROB_BITS_DEF,
	parameter int ENTRY_W   = PROB_BITS + 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  logic [ENTRY_W-1:0]         pop_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [brenc_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last
);
	import brenc_pkg::*;

	localparam int PROD_W = HALF_W + PROB_BITS;
	localparam int FULL_W = BOUND_W + 1 + PROB_BITS;
	localparam int FLAG_W = $bits(brenc_flags_t);

	brenc_state_t         state_q, state_d;
	logic [BOUND_W-1:0]   low_q, high_q;
	logic [BOUND_W:0]     rng_q;
	logic [PROB_BITS-1:0] p0_q;
	logic                 bit_q;
	logic [PROD_W-1:0]    prod_lo_q, prod_hi_q;
	logic [BOUND_W-1:0]   scaled_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q;

	brenc_flags_t         head_flags;
	logic [PROB_BITS-1:0] head_p0;
	logic                 slot_free;
	logic                 top_match;
	logic [HALF_W-1:0]    mul_a;
	logic [PROD_W-1:0]    mul_p;
	logic [FULL_W-1:0]    full;
	logic [BOUND_W-1:0]   split;

	logic                 load_cmd;
	logic                 emit;
	logic                 emit_last;
	logic                 shift_renorm;
	logic                 shift_flush;

	assign head_flags = brenc_flags_t'(pop_data[FLAG_W-1:0]);
	assign head_p0    = pop_data[ENTRY_W-1:FLAG_W];
	assign slot_free  = !out_valid_q || out_ready;
	assign top_match  = (low_q[BOUND_W-1 -: BYTE_W] == high_q[BOUND_W-1 -: BYTE_W]);

	// One 32 x PROB_BITS multiplier, shared by the two halves of the range.
	assign mul_a = (state_q == ST_MUL_LO) ? rng_q[HALF_W-1:0] : rng_q[BOUND_W-1:HALF_W];
	assign mul_p = PROD_W'(mul_a) * PROD_W'(p0_q);

	always_comb begin
		full = (FULL_W'(prod_hi_q) << HALF_W) + FULL_W'(prod_lo_q)
		     + (rng_q[BOUND_W] ? (FULL_W'(p0_q) << BOUND_W) : '0);
	end

	assign split = low_q + scaled_q - BOUND_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pop_ready    = 1'b0;
		load_cmd     = 1'b0;
		emit         = 1'b0;
		emit_last    = 1'b0;
		shift_renorm = 1'b0;
		shift_flush  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					load_cmd = 1'b1;
					state_d  = head_flags.finish ? ST_FLUSH : ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_NARROW;
			ST_NARROW: state_d = ST_RENORM;
			ST_RENORM: begin
				if (!top_match) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					emit         = 1'b1;
					shift_renorm = 1'b1;
					// Last byte when the count runs out or the next top bytes differ.
					emit_last = (cnt_q == CNT_W'(FLUSH_BYTES - 1))
					         || (low_q[BOUND_W-BYTE_W-1 -: BYTE_W]
					             != high_q[BOUND_W-BYTE_W-1 -: BYTE_W]);
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					emit        = 1'b1;
					shift_flush = 1'b1;
					emit_last   = (cnt_q == CNT_W'(FLUSH_BYTES - 1));
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_cmd) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_NARROW) begin
				if (bit_q) begin
					low_q <= low_q + scaled_q;
				end else begin
					high_q <= split;
				end
			end else if (shift_renorm) begin
				low_q  <= low_q << BYTE_W;
				high_q <= (high_q << BYTE_W) | BOUND_W'({BYTE_W{1'b1}});
			end else if (shift_flush) begin
				low_q <= low_q << BYTE_W;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			p0_q  <= head_p0;
			bit_q <= head_flags.bit_value;
			rng_q <= {1'b0, high_q} - {1'b0, low_q} + (BOUND_W + 1)'(1);
		end
		if (state_q == ST_MUL_LO) begin
			prod_lo_q <= mul_p;
		end
		if (state_q == ST_MUL_HI) begin
			prod_hi_q <= mul_p;
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= full[PROB_BITS +: BOUND_W];
		end
		if (emit) begin
			out_byte_q <= low_q[BOUND_W-1 -: BYTE_W];
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	// A finish command leaves the low bound cleared.
	a_flush_clears_low: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && emit && emit_last) |=> (low_q == '0))
		else $error("low bound not cleared after flush");

	// Renormalization stops as soon as the top bytes of the bounds differ.
	a_renorm_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RENORM && !top_match) |=> (state_q == ST_IDLE))
		else $error("renormalization continued with differing top bytes");

	// New output bytes come only from renormalization or flushing.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q == ST_RENORM || state_q == ST_FLUSH))
		else $error("byte emitted outside renormalization or flush");

	// The queue is drained only while the engine is idle.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> (state_q == ST_MUL_LO || state_q == ST_FLUSH))
		else $error("command taken without starting its work");
`endif

endmodule

### hdl/binary_range_encoder.sv
// Top level of the binary range encoder: input stream, command queue, interval engine.
// Depends on brenc_pkg, brenc_front, brenc_queue and brenc_back.
//
// Carryless binary range encoder with 64-bit low and high bounds. Each input beat is
// either an encode command (one bit and its probability of a one, in units of
// 1/2^PROB_BITS, with zero clamped up to one) or a finish command, selected by
// s_axis_tuser. Commands enter a small queue, so the input side keeps accepting while
// the interval engine works or the output stalls, until the queue is full. An encode
// command steps through queue pop, two halves of the range times probability on one
// shared 32 x PROB_BITS multiplier, scaling add and interval update, then emits zero
// to eight bytes, one per cycle while the output is not stalled; when no byte comes
// out, the renormalization state still checks the top bytes. A finish command sends
// the eight bytes of the low bound, most significant first; the low bound is then
// zero and encoding may continue. Output beats carry one byte each; m_axis_tlast
// marks the final byte caused by one command, and an encode command that produces no
// byte produces no beat. Output back pressure stalls only the byte loop.
module binary_range_encoder #(
	parameter int PROB_BITS   = brenc_pkg::PROB_BITS_DEF,
	parameter int QUEUE_DEPTH = brenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Bit 0: bit_value; bits PROB_BITS:1: prob_one; zero padding above.
	input  logic [((PROB_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
	// Bit 0: command (encode or finish).
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Bits 7:0: out_byte.
	output logic [brenc_pkg::BYTE_W-1:0]         m_axis_tdata,
	output logic                                 m_axis_tlast
);
	import brenc_pkg::*;

	localparam int IN_DATA_W = ((PROB_BITS + 8) / 8) * 8;
	localparam int ENTRY_W   = PROB_BITS + $bits(brenc_flags_t);

	logic               push_valid, push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid, pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	// Classifies each beat and computes the probability of a zero.
	brenc_front #(
		.PROB_BITS (PROB_BITS),
		.IN_DATA_W (IN_DATA_W),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_user     (s_axis_tuser),
		.s_data     (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	brenc_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Holds the bounds, narrows the interval and emits bytes through its output register.
	brenc_back #(
		.PROB_BITS (PROB_BITS),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### tb/brenc_checker.sv
// Stream checker for the binary range encoder: predicts the output bytes from the
// accepted input beats and compares them with the output beats.
// Depends on brenc_pkg for widths and command codes.
module brenc_stream_check
	import brenc_pkg::*;
#(
	parameter int PROB_BITS = PROB_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [((PROB_BITS + 8) / 8) * 8 - 1:0] s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [BYTE_W-1:0]                    m_tdata,
	input  logic                                 m_tlast,
	output int                                   mismatch_count,
	output int                                   bytes_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} coded_byte_t;

	logic [BOUND_W-1:0] low_bound;
	logic [BOUND_W-1:0] high_bound;
	coded_byte_t        bytes_due[$];
	int                 mismatches = 0;

	assign mismatch_count = mismatches;

	task automatic report_mismatch(input string msg);
		$display("%0t byte check: %s", $realtime, msg);
		mismatches++;
	endtask

	// Narrows the interval for one bit, then shifts out the settled top bytes, at most FLUSH_BYTES of them.
	task automatic code_bit(input logic bv, input logic [PROB_BITS-1:0] p1_raw);
		logic [PROB_BITS-1:0]         p1;
		logic [PROB_BITS:0]           p0;
		logic [BOUND_W:0]             span;
		logic [BOUND_W+PROB_BITS+1:0] prod;
		logic [BOUND_W-1:0]           cut;
		int                           n;
		bit                           more;
		coded_byte_t                  cb;
		p1 = (p1_raw == '0) ? PROB_BITS'(1) : p1_raw;
		p0 = {1'b1, {PROB_BITS{1'b0}}} - {1'b0, p1};
		// The span is taken modulo 2^65, so a wrapped interval still gives a defined split.
		span = {1'b0, high_bound} - {1'b0, low_bound} + 1'b1;
		prod = span * p0;
		cut = low_bound + prod[BOUND_W+PROB_BITS-1:PROB_BITS] - 1'b1;
		if (bv)
			low_bound = cut + 1'b1;
		else
			high_bound = cut;
		n = 0;
		more = (low_bound[BOUND_W-1 -: BYTE_W] == high_bound[BOUND_W-1 -: BYTE_W]);
		while (more) begin
			cb.value = low_bound[BOUND_W-1 -: BYTE_W];
			low_bound = low_bound << BYTE_W;
			high_bound = {high_bound[BOUND_W-BYTE_W-1:0], {BYTE_W{1'b1}}};
			n++;
			more = (n < FLUSH_BYTES) &&
				(low_bound[BOUND_W-1 -: BYTE_W] == high_bound[BOUND_W-1 -: BYTE_W]);
			cb.last = !more;
			bytes_due = {bytes_due, cb};
		end
	endtask

	task automatic flush_low();
		coded_byte_t cb;
		for (int k = 0; k < FLUSH_BYTES; k++) begin
			cb.value = low_bound[BOUND_W-1 -: BYTE_W];
			cb.last = (k == FLUSH_BYTES - 1);
			bytes_due = {bytes_due, cb};
			low_bound = low_bound << BYTE_W;
		end
	endtask

	// Output beats are compared before the input beat of the same edge is predicted,
	// so a stray output beat can never be matched against bytes that are not due yet.
	always @(posedge clk or negedge arst_n) begin
		coded_byte_t want;
		if (!arst_n) begin
			low_bound = '0;
			high_bound = '1;
			bytes_due.delete();
			bytes_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
				end else begin
					want = bytes_due.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last)
						report_mismatch($sformatf("got %02h last %0b, wanted %02h last %0b",
							m_tdata, m_tlast, want.value, want.last));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_FINISH)
					flush_low();
				else
					code_bit(s_tdata[0], s_tdata[PROB_BITS:1]);
			end
			bytes_pending <= bytes_due.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the binary range encoder testbench: clock, reset, stimulus and verdict.
// Depends on brenc_pkg, binary_range_encoder and brenc_stream_check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import brenc_pkg::*;

	localparam int PB      = PROB_BITS_DEF;
	localparam int TDATA_W = ((PB + 8) / 8) * 8;
	// Per phase of the random part; four phases give about 280 input beats.
	localparam int PHASE_ITEMS = 70;
	// An encode beat passes through the engine states and then emits at most eight bytes,
	// so these quiet cycles after the last byte show that nothing else is coming.
	localparam int TAIL_CYCLES = 40;
	// Longest quiet stretch allowed. The worst correct case is an 83% sender gap or
	// receiver stall on top of the engine latency; a quiet run as long as this limit
	// is already far beyond any plausible draw.
	localparam int STALL_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic               s_axis_tuser = CMD_ENCODE;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]  m_axis_tdata;
	logic               m_axis_tlast;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;
	int mismatch_count;
	int bytes_pending;

	always #2 clk = ~clk;

	binary_range_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	brenc_stream_check #(.PROB_BITS(PB)) byte_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.s_tuser        (s_axis_tuser),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tlast        (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.bytes_pending  (bytes_pending)
	);

	// The receiver drops ready at random; at zero percent it simply stays ready.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one beat and returns at the edge that accepts it. Valid is left high so
	// that back-to-back beats never lower and raise it in the same time step; any idle
	// gap lowers it at the start of the next call instead.
	task automatic send_item(input logic cmd, input logic bv, input logic [PB-1:0] p1);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= TDATA_W'({p1, bv});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Waits with valid low until every predicted byte has left the block. The first
	// edge lets the checker count the beat that was accepted last.
	task automatic drain_output();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0)
			@(posedge clk);
	endtask

	// Mostly encode beats: some with extreme probabilities, some whose bit follows its
	// probability the way real data does, the rest fully random. A few finish beats
	// carry random leftover fields, which the block must ignore.
	task automatic send_random_item();
		logic [PB-1:0] p1;
		logic          bv;
		int            pick;
		pick = $urandom_range(99);
		p1 = PB'($urandom_range((1 << PB) - 1));
		bv = 1'($urandom_range(1));
		if (pick < 4) begin
			send_item(CMD_FINISH, bv, p1);
		end else begin
			if (pick < 16) begin
				case ($urandom_range(5))
					0: p1 = '0;
					1: p1 = PB'(1);
					2: p1 = PB'(2);
					3: p1 = '1;
					4: p1 = '1 - PB'(1);
					default: p1 = PB'(1 << (PB - 1));
				endcase
			end else if (pick < 60) begin
				bv = ($urandom_range((1 << PB) - 1) < p1);
			end
			send_item(CMD_ENCODE, bv, p1);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset, squeeze the interval around the 0x7f/0x80 top-byte
		// boundary without emitting anything: each beat after the first shrinks it by
		// about 2^11 while keeping the boundary inside. The last beat codes a zero with the
		// smallest share, so the split falls below low and high ends up under low.
		// That state then shifts out seven bytes.
		send_item(CMD_ENCODE, 1'b0, PB'(2047));
		send_item(CMD_ENCODE, 1'b1, PB'(2));
		send_item(CMD_ENCODE, 1'b0, PB'(4094));
		send_item(CMD_ENCODE, 1'b1, PB'(2));
		send_item(CMD_ENCODE, 1'b0, PB'(4094));
		send_item(CMD_ENCODE, 1'b1, PB'(2));
		send_item(CMD_ENCODE, 1'b0, PB'(4095));
		// High still lies under low after that: an even split emits no byte at all.
		send_item(CMD_ENCODE, 1'b0, PB'(2048));
		// Finish twice; the second one flushes an all-zero low bound and carries
		// leftover fields set to ones.
		send_item(CMD_FINISH, 1'b0, '0);
		send_item(CMD_FINISH, 1'b1, '1);
		// A zero probability is clamped up to one, for both bit values.
		send_item(CMD_ENCODE, 1'b1, '0);
		send_item(CMD_ENCODE, 1'b0, '0);
		send_item(CMD_ENCODE, 1'b1, '1);
		send_item(CMD_ENCODE, 1'b0, '1);
		send_item(CMD_ENCODE, 1'b1, PB'(1));
		send_item(CMD_ENCODE, 1'b0, PB'(1));
		send_item(CMD_ENCODE, 1'b1, PB'(2048));
		send_item(CMD_ENCODE, 1'b0, PB'(12'haaa));
		send_item(CMD_ENCODE, 1'b1, PB'(12'h555));
		send_item(CMD_FINISH, 1'b0, '0);

		// Random part in four flow-control phases: free flow, a mostly idle sender,
		// a mostly stalled receiver, and light idling on both sides.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 83;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 83;
				end
				default: begin
					src_idle_pct = 14;
					sink_stall_pct = 14;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Once in the run, hold the input back until the output has caught up.
				if (phase == 2 && k == PHASE_ITEMS / 2)
					drain_output();
				send_random_item();
			end
		end

		drain_output();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

### sim.f
hdl/brenc_pkg.sv
hdl/brenc_front.sv
hdl/brenc_queue.sv
hdl/brenc_back.sv
hdl/binary_range_encoder.sv
tb/brenc_checker.sv
tb/tb.sv
